// ===== hdl/rba_pkg.sv =====
// ----------------------------------------------------------------------------
// rba_pkg: shared types and constants for the ring buffer allocator
// Offsets, request and result records, and the state record of the ring.
// ----------------------------------------------------------------------------
package rba_pkg;

  // Field widths
  localparam int unsigned ST_W  = 17;  // offsets held in state, sizes, lengths
  localparam int unsigned OFF_W = 16;  // reported offset, free offset

  // Default upper bound on the usable buffer length
  localparam int unsigned MAX_BUFFER_LEN_DEF = 65536;

  // Buffer length after reset
  localparam logic [ST_W-1:0] LEN_RESET = 17'd65536;

  // Stream payload widths (padded to whole bytes)
  localparam int unsigned S_DATA_W = 40;  // size, free_offset
  localparam int unsigned M_DATA_W = 40;  // granted, alloc_offset, allocated_amount

  // Request kind
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ST_W-1:0]  size;
    logic [OFF_W-1:0] free_offset;
  } rba_req_t;

  typedef struct packed {
    logic             granted;
    logic [OFF_W-1:0] alloc_offset;
    logic [ST_W-1:0]  allocated_amount;
  } rba_res_t;

  typedef struct packed {
    logic [ST_W-1:0] oldest_live;
    logic [ST_W-1:0] next_free;
    logic [ST_W-1:0] wrap_point;
    logic            wrap_active;
  } rba_state_t;

endpackage

// ===== hdl/rba_step.sv =====
// ----------------------------------------------------------------------------
// rba_step: next-state and result logic for one request
// Places or releases one block against the current ring state and works out
// the byte count held after the request, clamped between zero and the buffer length.
// ----------------------------------------------------------------------------
module rba_step import rba_pkg::*; (
  input  rba_state_t      cur,
  input  rba_req_t        req,
  input  logic [ST_W-1:0] eff_len,
  output rba_state_t      nxt,
  output rba_res_t        res
);

  logic [ST_W:0]   nf_end;
  logic            fit_here;
  logic            fit_low;
  logic [ST_W-1:0] ol_sum;
  logic [ST_W-1:0] wp_sum;
  logic [ST_W-1:0] off_full;
  logic            granted;
  logic [ST_W+1:0] raw_amt;
  logic [ST_W+1:0] tail_amt;
  logic [ST_W-1:0] amt;

  // Placement tests: at next_free, or wrapped to offset zero
  assign nf_end   = {1'b0, cur.next_free} + {1'b0, req.size};
  assign fit_here = (nf_end <= {1'b0, eff_len}) &&
                    !(cur.wrap_active && (cur.wrap_point >= cur.next_free) &&
                      ({1'b0, cur.wrap_point} < nf_end));
  assign fit_low  = (cur.oldest_live >= req.size) &&
                    !(cur.wrap_active && (cur.wrap_point < req.size));

  // Free advances wrap modulo 2^17
  assign ol_sum = cur.oldest_live + req.size;
  assign wp_sum = cur.wrap_point + req.size;

  // State update
  always_comb begin
    nxt      = cur;
    granted  = 1'b0;
    off_full = '0;
    case (req.op)
      OP_ALLOC: begin
        if (fit_here) begin
          granted       = 1'b1;
          off_full      = cur.next_free;
          nxt.next_free = nf_end[ST_W-1:0];
        end else if (fit_low) begin
          granted         = 1'b1;
          nxt.wrap_point  = cur.oldest_live;
          nxt.wrap_active = 1'b1;
          nxt.oldest_live = '0;
          nxt.next_free   = req.size;
        end
      end
      OP_FREE: begin
        granted = 1'b1;
        if (!cur.wrap_active) begin
          nxt.oldest_live = ol_sum;
        end else if (req.free_offset == '0) begin
          nxt.wrap_active = 1'b0;
          nxt.wrap_point  = '0;
          nxt.oldest_live = req.size;
        end else begin
          nxt.wrap_point = wp_sum;
        end
        // drained: restart at the bottom
        if (!nxt.wrap_active && (nxt.oldest_live == cur.next_free)) begin
          nxt.oldest_live = '0;
          nxt.next_free   = '0;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  // Live byte count, two's complement in ST_W+2 bits, then clamped
  assign tail_amt = nxt.wrap_active ? ({2'b00, eff_len} - {2'b00, nxt.wrap_point}) : '0;
  assign raw_amt  = {2'b00, nxt.next_free} - {2'b00, nxt.oldest_live} + tail_amt;

  always_comb begin
    if (raw_amt[ST_W+1]) begin
      amt = '0;
    end else if (raw_amt[ST_W:0] > {1'b0, eff_len}) begin
      amt = eff_len;
    end else begin
      amt = raw_amt[ST_W-1:0];
    end
  end

  assign res.granted          = granted;
  assign res.alloc_offset     = off_full[OFF_W-1:0];
  assign res.allocated_amount = amt;

endmodule

// ===== hdl/ring_buffer_allocator.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_allocator: in-order ring allocator over a configurable buffer
//
//   channel | dir | handshake        | payload
//   --------+-----+------------------+-------------------------------------
//   s_      | in  | s_tvalid/tready  | tdata: size, free_offset; tuser: op
//   m_      | out | m_tvalid/tready  | tdata: granted, offset, amount
//   cfg_    | in  | cfg_we           | cfg_wdata: buffer_len
//
// One request per cycle sustained while m_tready stays high; each result
// passes the input register, then the result register. The ring state updates
// in the same cycle a request moves from the input register to the result
// register. Reset clears the ring to empty and sets buffer_len to 65536.
// A stalled m_ side holds the result; the input register keeps taking one
// request while the result waits, then s_tready drops.
// ----------------------------------------------------------------------------
module ring_buffer_allocator import rba_pkg::*; #(
  parameter int unsigned MAX_BUFFER_LEN = MAX_BUFFER_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // request stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [16:0] size, [32:17] free_offset, rest zero
  input  logic                s_tuser,   // [0] op
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // [0] granted, [16:1] alloc_offset,
                                         // [33:17] allocated_amount, rest zero
  // configuration
  input  logic                cfg_we,
  input  logic [ST_W-1:0]     cfg_wdata
);

  // Cap on the length, limited to what the length register can hold
  localparam int unsigned LenCap =
    (MAX_BUFFER_LEN > (2**ST_W - 1)) ? (2**ST_W - 1) : MAX_BUFFER_LEN;

  logic [ST_W-1:0] buffer_len;
  logic [ST_W-1:0] eff_len;

  logic       in_valid;
  rba_req_t   in_req;
  rba_req_t   s_req;
  logic       s_xfer;
  logic       advance;

  rba_state_t state;
  rba_state_t state_next;
  rba_res_t   step_res;
  rba_res_t   out_res;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_len <= LEN_RESET;
    end else if (cfg_we) begin
      buffer_len <= cfg_wdata;
    end
  end

  assign eff_len = (buffer_len > ST_W'(LenCap)) ? ST_W'(LenCap) : buffer_len;

  // Unpack request
  assign s_req.op          = op_t'(s_tuser);
  assign s_req.size        = s_tdata[ST_W-1:0];
  assign s_req.free_offset = s_tdata[ST_W+OFF_W-1:ST_W];

  // Handshake control
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_xfer   = s_tvalid && s_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_xfer) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      in_req <= s_req;
    end
  end

  // Request evaluation
  rba_step u_step (
    .cur     (state),
    .req     (in_req),
    .eff_len (eff_len),
    .nxt     (state_next),
    .res     (step_res)
  );

  // Ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tdata = {{(M_DATA_W - 1 - OFF_W - ST_W){1'b0}},
                    out_res.allocated_amount, out_res.alloc_offset, out_res.granted};

  // Checks
  a_wrap_clear: assert property (@(posedge clk) disable iff (rst)
    !state.wrap_active |-> (state.wrap_point == '0))
    else $error("wrap point set while not wrapped");

  a_refused_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (advance && !step_res.granted) |=> $stable(state))
    else $error("refused request changed ring state");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("evaluated request left no result");

  a_held_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_req)))
    else $error("pending request lost while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input refused with empty input register");

endmodule
